FILE: rtl/core/complex_ratio_to_polar_macros.svh
// Assertion macros shared by the impedance pipeline.
`ifndef COMPLEX_RATIO_TO_POLAR_MACROS_SVH
`define COMPLEX_RATIO_TO_POLAR_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define CRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked in every cycle including reset.
`define CRP_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/crp_pkg.sv
// Types, constants and the arctangent table of the impedance pipeline.
package crp_pkg;

    localparam int NORM_STEPS  = 6;
    localparam int ANGLE_STEPS = 30;
    localparam int DIV_STEPS   = 96;
    localparam int SQRT_STEPS  = 32;

    localparam logic signed [33:0] PI_Q30    = 34'sd3373259426;
    localparam logic signed [33:0] HALF_LSB  = 34'sd65536;
    localparam logic [31:0]        MAG_SAT   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] voltage_real;
        logic signed [31:0] voltage_imag;
        logic signed [31:0] current_real;
        logic signed [31:0] current_imag;
    } t_in;

    typedef struct packed {
        logic [31:0]        magnitude;
        logic signed [15:0] phase;
        logic               zero_current;
    } t_out;

    // Products stage output: |V|^2, |I|^2 and V*conj(I) as sign and magnitude.
    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] ax;
        logic [63:0] ay;
        logic        xneg;
        logic        yneg;
        logic        zc;
    } t_prod;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic        xneg;
        logic        yneg;
        logic        zc;
    } t_side;

    typedef struct packed {
        logic [63:0]        num;
        logic [63:0]        den;
        logic signed [15:0] phase;
        logic               zc;
    } t_ratio;

    typedef struct packed {
        logic [63:0]        quot;
        logic               ovf;
        logic signed [15:0] phase;
        logic               zc;
    } t_quot;

    // atan(2^-i) in radians * 2^30, rounded.
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            default: v = 30'(30'd1 << (30 - idx));
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/complex_ratio_to_polar.sv
// Top level: impedance V/I of one spectrum bin as magnitude and phase.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  input    | start, busy               | i_item  (t_in)
//  result   | o_strobe (one cycle)      | o_result (t_out)
//
// A beat enters on every cycle that start is high; busy is tied low.
// Each result passes through 3 product stages, 6 normalize, 30 CORDIC
// and 1 rounding stages, 96 divider stages, 32 square root stages and
// the output register. The divider sets the depth.
// Synchronous reset clears all valid bits; data registers are not reset.
// Nothing stalls: the pipeline advances every cycle.
`include "complex_ratio_to_polar_macros.svh"

module complex_ratio_to_polar
    import crp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_out o_result
);

    logic   w_acc;
    logic   w_fv, w_pv, w_dv, w_sv;
    t_prod  w_fd;
    t_ratio w_pd;
    t_quot  w_dd;
    t_out   w_sd;
    logic   r_strobe;
    t_out   r_result;

    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    crp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_item  (i_item),
        .o_valid (w_fv),
        .o_data  (w_fd)
    );

    crp_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .i_data  (w_fd),
        .o_valid (w_pv),
        .o_data  (w_pd)
    );

    crp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pv),
        .i_data  (w_pd),
        .o_valid (w_dv),
        .o_data  (w_dd)
    );

    crp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv),
        .i_data  (w_dd),
        .o_valid (w_sv),
        .o_data  (w_sd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= w_sd;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `CRP_ASSERT_NEXT(a_no_strobe_after_reset, i_clk, !i_rst_n, !o_strobe,
        "result strobe right after reset")
    `CRP_ASSERT_NOW(a_zero_current_clears, i_clk, i_rst_n,
        o_strobe && o_result.zero_current,
        (o_result.magnitude == 32'd0) && (o_result.phase == 16'sd0),
        "zero current bin with nonzero magnitude or phase")
    `CRP_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, o_strobe,
        (o_result.phase <= 16'sd25736) && (o_result.phase >= -16'sd25736),
        "phase outside minus pi to pi")

endmodule

FILE: rtl/core/crp_front.sv
// Input register, operand products and sums for magnitude and phase.
module crp_front
    import crp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_item,
    output logic  o_valid,
    output t_prod o_data
);

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    logic r_v1, r_v2, r_v3;
    t_in  r_in;
    logic r_zc1, r_zc2;
    logic [63:0] r_vr2, r_vi2, r_ir2, r_ii2;
    logic signed [63:0] r_rr, r_qq, r_ir, r_ri;
    t_prod r_out;

    logic signed [64:0] w_x, w_y;
    logic [64:0] w_xn, w_yn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= i_item;
        r_zc1 <= (i_item.current_real == '0) && (i_item.current_imag == '0);
    end

    always_ff @(posedge i_clk) begin
        r_zc2 <= r_zc1;
        r_vr2 <= {32'd0, abs32(r_in.voltage_real)} * {32'd0, abs32(r_in.voltage_real)};
        r_vi2 <= {32'd0, abs32(r_in.voltage_imag)} * {32'd0, abs32(r_in.voltage_imag)};
        r_ir2 <= {32'd0, abs32(r_in.current_real)} * {32'd0, abs32(r_in.current_real)};
        r_ii2 <= {32'd0, abs32(r_in.current_imag)} * {32'd0, abs32(r_in.current_imag)};
        r_rr  <= 64'($signed(r_in.voltage_real)) * 64'($signed(r_in.current_real));
        r_qq  <= 64'($signed(r_in.voltage_imag)) * 64'($signed(r_in.current_imag));
        r_ir  <= 64'($signed(r_in.voltage_imag)) * 64'($signed(r_in.current_real));
        r_ri  <= 64'($signed(r_in.voltage_real)) * 64'($signed(r_in.current_imag));
    end

    assign w_x  = {r_rr[63], r_rr} + {r_qq[63], r_qq};
    assign w_y  = {r_ir[63], r_ir} - {r_ri[63], r_ri};
    assign w_xn = 65'(-w_x);
    assign w_yn = 65'(-w_y);

    always_ff @(posedge i_clk) begin
        r_out.num  <= r_vr2 + r_vi2;
        r_out.den  <= r_ir2 + r_ii2;
        r_out.ax   <= w_x[64] ? w_xn[63:0] : w_x[63:0];
        r_out.ay   <= w_y[64] ? w_yn[63:0] : w_y[63:0];
        r_out.xneg <= w_x[64];
        r_out.yneg <= w_y[64];
        r_out.zc   <= r_zc2;
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/crp_phase.sv
// Phase path: common normalization, CORDIC vectoring stages, quadrant and rounding.
module crp_phase
    import crp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_prod  i_data,
    output logic   o_valid,
    output t_ratio o_data
);

    logic        r_nv [NORM_STEPS];
    logic [63:0] r_nm [NORM_STEPS];
    logic [63:0] r_nx [NORM_STEPS];
    logic [63:0] r_ny [NORM_STEPS];
    t_side       r_ns [NORM_STEPS];

    logic               r_cv [ANGLE_STEPS];
    logic signed [32:0] r_cx [ANGLE_STEPS];
    logic signed [32:0] r_cy [ANGLE_STEPS];
    logic signed [32:0] r_cz [ANGLE_STEPS];
    t_side              r_cs [ANGLE_STEPS];

    logic   r_fv;
    t_ratio r_fo;

    // Left-justify the larger operand at bit 63; bits [63:34] then hold both
    // values scaled so the larger lies in [2^29, 2^30).
    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic        w_v;
        logic [63:0] w_m, w_x, w_y;
        t_side       w_s;
        if (k == 0) begin : g_first
            assign w_v = i_valid;
            assign w_x = i_data.ax;
            assign w_y = i_data.ay;
            assign w_m = (i_data.ax > i_data.ay) ? i_data.ax : i_data.ay;
            assign w_s = '{num: i_data.num, den: i_data.den, xneg: i_data.xneg,
                           yneg: i_data.yneg, zc: i_data.zc};
        end else begin : g_next
            assign w_v = r_nv[k-1];
            assign w_x = r_nx[k-1];
            assign w_y = r_ny[k-1];
            assign w_m = r_nm[k-1];
            assign w_s = r_ns[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[k] <= 1'b0;
            end else begin
                r_nv[k] <= w_v;
            end
        end
        always_ff @(posedge i_clk) begin
            r_ns[k] <= w_s;
            if (w_m[63 -: SH] == '0) begin
                r_nm[k] <= w_m << SH;
                r_nx[k] <= w_x << SH;
                r_ny[k] <= w_y << SH;
            end else begin
                r_nm[k] <= w_m;
                r_nx[k] <= w_x;
                r_ny[k] <= w_y;
            end
        end
    end

    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cordic
        logic               w_v;
        logic signed [32:0] w_x, w_y, w_z, w_dx, w_dy, w_a;
        t_side              w_s;
        if (i == 0) begin : g_first
            assign w_v = r_nv[NORM_STEPS-1];
            assign w_x = $signed({3'b000, r_nx[NORM_STEPS-1][63:34]});
            assign w_y = $signed({3'b000, r_ny[NORM_STEPS-1][63:34]});
            assign w_z = '0;
            // A negative y that normalizes to zero keeps its angle positive.
            assign w_s = '{num: r_ns[NORM_STEPS-1].num, den: r_ns[NORM_STEPS-1].den,
                           xneg: r_ns[NORM_STEPS-1].xneg,
                           yneg: r_ns[NORM_STEPS-1].yneg
                                 && (r_ny[NORM_STEPS-1][63:34] != '0),
                           zc: r_ns[NORM_STEPS-1].zc};
        end else begin : g_next
            assign w_v = r_cv[i-1];
            assign w_x = r_cx[i-1];
            assign w_y = r_cy[i-1];
            assign w_z = r_cz[i-1];
            assign w_s = r_cs[i-1];
        end
        assign w_dx = w_y >>> i;
        assign w_dy = w_x >>> i;
        assign w_a  = $signed({3'b000, atan_q30(i)});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i] <= 1'b0;
            end else begin
                r_cv[i] <= w_v;
            end
        end
        always_ff @(posedge i_clk) begin
            r_cs[i] <= w_s;
            if (w_y[32]) begin
                r_cx[i] <= w_x - w_dx;
                r_cy[i] <= w_y + w_dy;
                r_cz[i] <= w_z - w_a;
            end else if (w_y != '0) begin
                r_cx[i] <= w_x + w_dx;
                r_cy[i] <= w_y - w_dy;
                r_cz[i] <= w_z + w_a;
            end else begin
                r_cx[i] <= w_x;
                r_cy[i] <= w_y;
                r_cz[i] <= w_z;
            end
        end
    end

    logic signed [33:0] w_zc, w_zq, w_zr;
    logic signed [15:0] w_t;
    t_side              w_ls;

    assign w_ls = r_cs[ANGLE_STEPS-1];
    assign w_zc = r_cz[ANGLE_STEPS-1][32] ? 34'sd0
                                          : {r_cz[ANGLE_STEPS-1][32], r_cz[ANGLE_STEPS-1]};
    assign w_zq = w_ls.xneg ? (PI_Q30 - w_zc) : w_zc;
    assign w_zr = w_zq + HALF_LSB;
    assign w_t  = w_zr[32:17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= r_cv[ANGLE_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fo.num   <= w_ls.num;
        r_fo.den   <= w_ls.den;
        r_fo.zc    <= w_ls.zc;
        r_fo.phase <= w_ls.yneg ? 16'(-w_t) : w_t;
    end

    assign o_valid = r_fv;
    assign o_data  = r_fo;

endmodule

FILE: rtl/core/crp_div.sv
// Restoring long division, one quotient bit per stage: floor(num * 2^32 / den).
module crp_div
    import crp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_ratio i_data,
    output logic   o_valid,
    output t_quot  o_data
);

    logic               r_v   [DIV_STEPS];
    logic [63:0]        r_rem [DIV_STEPS];
    logic [63:0]        r_num [DIV_STEPS];
    logic [63:0]        r_den [DIV_STEPS];
    logic [63:0]        r_q   [DIV_STEPS];
    logic               r_ovf [DIV_STEPS];
    logic signed [15:0] r_ph  [DIV_STEPS];
    logic               r_zc  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic               w_v, w_ovf, w_zc, w_ge;
        logic [63:0]        w_rem, w_num, w_den, w_q;
        logic signed [15:0] w_ph;
        logic [64:0]        w_rs, w_diff;
        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = '0;
            assign w_num = i_data.num;
            assign w_den = i_data.den;
            assign w_q   = '0;
            assign w_ovf = 1'b0;
            assign w_ph  = i_data.phase;
            assign w_zc  = i_data.zc;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_den = r_den[k-1];
            assign w_q   = r_q[k-1];
            assign w_ovf = r_ovf[k-1];
            assign w_ph  = r_ph[k-1];
            assign w_zc  = r_zc[k-1];
        end
        // The dividend is shifted out from the top; past bit 64 it is all zeros.
        assign w_rs   = {w_rem, w_num[63]};
        assign w_ge   = w_rs >= {1'b0, w_den};
        assign w_diff = w_rs - {1'b0, w_den};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v;
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_diff[63:0] : w_rs[63:0];
            r_num[k] <= {w_num[62:0], 1'b0};
            r_den[k] <= w_den;
            r_q[k]   <= {w_q[62:0], w_ge};
            r_ovf[k] <= w_ovf | w_q[63];
            r_ph[k]  <= w_ph;
            r_zc[k]  <= w_zc;
        end
    end

    assign o_valid       = r_v[DIV_STEPS-1];
    assign o_data.quot   = r_q[DIV_STEPS-1];
    assign o_data.ovf    = r_ovf[DIV_STEPS-1];
    assign o_data.phase  = r_ph[DIV_STEPS-1];
    assign o_data.zc     = r_zc[DIV_STEPS-1];

endmodule

FILE: rtl/core/crp_sqrt.sv
// Integer square root of the quotient, one result bit per stage, and result forming.
module crp_sqrt
    import crp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_quot i_data,
    output logic  o_valid,
    output t_out  o_data
);

    logic               r_v   [SQRT_STEPS];
    logic [63:0]        r_rad [SQRT_STEPS];
    logic [63:0]        r_res [SQRT_STEPS];
    logic               r_ovf [SQRT_STEPS];
    logic signed [15:0] r_ph  [SQRT_STEPS];
    logic               r_zc  [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic               w_v, w_ovf, w_zc, w_ge;
        logic [63:0]        w_rad, w_res, w_sum;
        logic signed [15:0] w_ph;
        if (j == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rad = i_data.quot;
            assign w_res = '0;
            assign w_ovf = i_data.ovf;
            assign w_ph  = i_data.phase;
            assign w_zc  = i_data.zc;
        end else begin : g_next
            assign w_v   = r_v[j-1];
            assign w_rad = r_rad[j-1];
            assign w_res = r_res[j-1];
            assign w_ovf = r_ovf[j-1];
            assign w_ph  = r_ph[j-1];
            assign w_zc  = r_zc[j-1];
        end
        assign w_sum = w_res + BIT;
        assign w_ge  = w_rad >= w_sum;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= w_v;
            end
        end
        always_ff @(posedge i_clk) begin
            r_rad[j] <= w_ge ? (w_rad - w_sum) : w_rad;
            r_res[j] <= w_ge ? ((w_res >> 1) + BIT) : (w_res >> 1);
            r_ovf[j] <= w_ovf;
            r_ph[j]  <= w_ph;
            r_zc[j]  <= w_zc;
        end
    end

    logic w_zc, w_ovf;
    assign w_zc  = r_zc[SQRT_STEPS-1];
    assign w_ovf = r_ovf[SQRT_STEPS-1];

    assign o_valid             = r_v[SQRT_STEPS-1];
    assign o_data.magnitude    = w_zc  ? 32'd0 :
                                 w_ovf ? MAG_SAT : r_res[SQRT_STEPS-1][31:0];
    assign o_data.phase        = w_zc ? 16'sd0 : r_ph[SQRT_STEPS-1];
    assign o_data.zero_current = w_zc;

endmodule
